// ----- rtl/oaht_pkg.sv -----
// Shared types and constants of the open-addressing hash table.
package oaht_pkg;

	localparam int REQ_W      = 2;
	localparam int KEY_W      = 32;
	localparam int STAT_W     = 3;
	localparam int SLOT_W     = 4;
	localparam int CNT_W      = 5;
	localparam int SZ_W       = 5;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_ADDR_W = 1;

	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd0;
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

	localparam logic [STAT_W-1:0] RES_OK        = 3'd0;
	localparam logic [STAT_W-1:0] RES_NOT_FOUND = 3'd1;
	localparam logic [STAT_W-1:0] RES_DUP       = 3'd2;
	localparam logic [STAT_W-1:0] RES_LOAD      = 3'd3;
	localparam logic [STAT_W-1:0] RES_NO_SLOT   = 3'd4;

	localparam logic [CFG_ADDR_W-1:0] CFG_PROBE_MODE = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] CFG_TABLE_SIZE = 1'b1;

	localparam logic [SZ_W-1:0] MIN_SIZE   = 5'd3;
	localparam logic [SZ_W-1:0] RESET_SIZE = 5'd8;

	typedef struct packed {
		logic load;
		logic hash;
		logic scan;
		logic prep;
		logic probe;
		logic out_load;
	} oaht_cmd_t;

	typedef struct packed {
		logic hash_last;
		logic scan_done;
		logic refuse;
		logic probe_done;
	} oaht_sts_t;

endpackage

// ----- rtl/oaht_if.sv -----
// Request, response and configuration channel interfaces.
interface oaht_req_if import oaht_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [KEY_W-1:0] key;

	modport source (output valid, output req_type, output key, input ready);
	modport sink (input valid, input req_type, input key, output ready);
endinterface

interface oaht_rsp_if import oaht_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [SLOT_W-1:0] slot_index;
	logic [CNT_W-1:0]  probe_count;

	modport source (output valid, output status, output slot_index, output probe_count,
		input ready);
	modport sink (input valid, input status, input slot_index, input probe_count,
		output ready);
endinterface

interface oaht_cfg_if import oaht_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

// ----- rtl/oaht_ctrl.sv -----
// Sequencer of the hash table: hash, duplicate scan, probe and reply phases.
module oaht_ctrl import oaht_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [REQ_W-1:0] req_type,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  oaht_sts_t        sts,
	output oaht_cmd_t        cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_SCAN,
		S_PREP,
		S_PROBE,
		S_REPLY
	} state_t;

	state_t           state_q;
	logic [REQ_W-1:0] op_q;
	logic             rsp_valid_q;
	logic             accept;
	logic             out_free;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.hash     = (state_q == S_HASH);
		cmd.scan     = (state_q == S_SCAN);
		cmd.prep     = (state_q == S_PREP);
		cmd.probe    = (state_q == S_PROBE);
		cmd.out_load = (state_q == S_REPLY) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= REQ_SEARCH;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_REPLY) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= req_type;
						state_q <= (req_type == REQ_CLEAR) ? S_REPLY : S_HASH;
					end
				end
				S_HASH: begin
					if (sts.hash_last) begin
						state_q <= (op_q == REQ_INSERT) ? S_SCAN : S_PREP;
					end
				end
				S_SCAN: begin
					if (sts.scan_done) begin
						state_q <= sts.refuse ? S_REPLY : S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (sts.probe_done) begin
						state_q <= S_REPLY;
					end
				end
				S_REPLY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/oaht_dp.sv -----
// Datapath of the hash table: config, key hashing, slot memory, probe pipeline, results.
module oaht_dp import oaht_pkg::*; #(
	parameter int TABLE_DEPTH = 16,
	parameter int KEY_WIDTH   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  oaht_cmd_t             cmd,
	output oaht_sts_t             sts,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [KEY_W-1:0]      req_key,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [STAT_W-1:0]     status,
	output logic [SLOT_W-1:0]     slot_index,
	output logic [CNT_W-1:0]      probe_count
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int BW = $clog2(KEY_WIDTH);
	localparam int MW = KEY_WIDTH + 1;

	logic                   probe_mode_q;
	logic [SZ_W-1:0]        table_size_q;
	logic [SZ_W-1:0]        size;
	logic [SZ_W:0]          size_ext;

	logic [KEY_WIDTH-1:0]   key_q;
	logic [REQ_W-1:0]       op_q;
	logic [BW-1:0]          bit_q;
	logic [SZ_W-1:0]        rem_q;
	logic [SZ_W:0]          rem_ext;
	logic [SZ_W-1:0]        rem_d;

	logic [SZ_W-1:0]        addr_q;
	logic [SZ_W-1:0]        inc_q;
	logic [SZ_W-1:0]        iss_q;
	logic [SZ_W-1:0]        occ_q;
	logic [SZ_W:0]          addr_sum;
	logic [SZ_W-1:0]        addr_nx;
	logic [SZ_W:0]          inc_sum;
	logic [SZ_W-1:0]        inc_nx;
	logic                   issue;

	logic                   valid_s1;
	logic [SZ_W-1:0]        addr_s1;
	logic [SZ_W-1:0]        cnt_s1;
	logic [MW-1:0]          rd_s1;
	logic [IW-1:0]          ix_s1;

	logic [MW-1:0]          mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] live_q;

	logic                   live;
	logic                   occ;
	logic                   match;
	logic                   last;
	logic [SZ_W-1:0]        occ_sum;
	logic                   is_ins;
	logic                   probe_hit;

	logic                   mem_we;
	logic [MW-1:0]          mem_wd;

	logic [STAT_W-1:0]      res_status_q;
	logic [SLOT_W-1:0]      res_slot_q;
	logic [CNT_W-1:0]       res_cnt_q;
	logic [STAT_W-1:0]      status_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [CNT_W-1:0]       count_q;

	always_comb begin
		if (table_size_q < MIN_SIZE) begin
			size = MIN_SIZE;
		end else if (int'(table_size_q) > TABLE_DEPTH) begin
			size = SZ_W'(TABLE_DEPTH);
		end else begin
			size = table_size_q;
		end
	end
	assign size_ext = {1'b0, size};

	assign rem_ext = {rem_q, key_q[bit_q]};
	assign rem_d   = (rem_ext >= size_ext) ? SZ_W'(rem_ext - size_ext) : SZ_W'(rem_ext);

	assign addr_sum = {1'b0, addr_q} + {1'b0, inc_q};
	assign addr_nx  = (addr_sum >= size_ext) ? SZ_W'(addr_sum - size_ext) : SZ_W'(addr_sum);
	assign inc_sum  = {1'b0, inc_q} + (SZ_W+1)'(2);
	assign inc_nx   = (inc_sum >= size_ext) ? SZ_W'(inc_sum - size_ext) : SZ_W'(inc_sum);
	assign issue    = (cmd.scan || cmd.probe) && (iss_q < size);

	assign ix_s1     = IW'(addr_s1);
	assign live      = live_q[ix_s1];
	assign occ       = live && !rd_s1[MW-1];
	assign match     = occ && (rd_s1[KEY_WIDTH-1:0] == key_q);
	assign last      = (cnt_s1 == size);
	assign occ_sum   = occ_q + SZ_W'(occ);
	assign is_ins    = (op_q == REQ_INSERT);
	assign probe_hit = is_ins ? !occ : (!live || match);

	assign sts.hash_last  = cmd.hash && (bit_q == '0);
	assign sts.scan_done  = cmd.scan && valid_s1 && (match || last);
	assign sts.refuse     = match || (occ_sum >= size - SZ_W'(1));
	assign sts.probe_done = cmd.probe && valid_s1 && (probe_hit || last);

	assign mem_we = sts.probe_done && probe_hit && (is_ins || (op_q == REQ_REMOVE && match));
	assign mem_wd = {!is_ins, key_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_mode_q <= 1'b0;
			table_size_q <= RESET_SIZE;
			live_q       <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_PROBE_MODE: probe_mode_q <= cfg_data[0];
					CFG_TABLE_SIZE: table_size_q <= cfg_data;
					default: ;
				endcase
				live_q <= '0;
			end else if (cmd.load && req_type == REQ_CLEAR) begin
				live_q <= '0;
			end else if (mem_we && is_ins) begin
				live_q[ix_s1] <= 1'b1;
			end
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[ix_s1] <= mem_wd;
		end
		rd_s1 <= mem[IW'(addr_q)];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= KEY_WIDTH'(req_key);
			op_q   <= req_type;
			bit_q  <= BW'(KEY_WIDTH - 1);
			rem_q  <= '0;
			addr_q <= '0;
			iss_q  <= '0;
			occ_q  <= '0;
		end else if (cmd.hash) begin
			rem_q <= rem_d;
			bit_q <= bit_q - BW'(1);
		end else if (cmd.prep) begin
			addr_q <= rem_q;
			inc_q  <= SZ_W'(1);
			iss_q  <= '0;
		end else if (issue) begin
			iss_q <= iss_q + SZ_W'(1);
			if (cmd.scan) begin
				addr_q <= addr_q + SZ_W'(1);
			end else begin
				addr_q <= addr_nx;
				if (probe_mode_q) begin
					inc_q <= inc_nx;
				end
			end
		end
		if (cmd.scan && valid_s1) begin
			occ_q <= occ_sum;
		end
		addr_s1 <= addr_q;
		cnt_s1  <= iss_q + SZ_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_status_q <= RES_OK;
			res_slot_q   <= '0;
			res_cnt_q    <= '0;
		end else if (sts.scan_done) begin
			res_status_q <= match ? RES_DUP : RES_LOAD;
			res_slot_q   <= '0;
			res_cnt_q    <= '0;
		end else if (sts.probe_done) begin
			res_cnt_q <= CNT_W'(cnt_s1);
			if (probe_hit && (is_ins || match)) begin
				res_status_q <= RES_OK;
				res_slot_q   <= SLOT_W'(addr_s1);
			end else begin
				res_status_q <= (is_ins && !probe_hit) ? RES_NO_SLOT : RES_NOT_FOUND;
				res_slot_q   <= '0;
			end
		end
		if (cmd.out_load) begin
			status_q <= res_status_q;
			slot_q   <= res_slot_q;
			count_q  <= res_cnt_q;
		end
	end

	assign status      = status_q;
	assign slot_index  = slot_q;
	assign probe_count = count_q;

endmodule

// ----- rtl/open_addressing_hash_table.sv -----
// Top level of the open-addressing hash table with linear or quadratic probing.
//
// One request is worked at a time. A clear goes from acceptance straight to
// the reply. Every other request first reduces the key modulo the table size
// one key bit per cycle. An insert then reads each slot once through the slot
// memory's single read port to look for a duplicate and count the load,
// stopping early at a duplicate; search, remove and an accepted insert then
// walk the probe path one slot per cycle through the same port. A new
// request is taken while the previous response still waits in the output
// register. Writing either configuration register empties the table.
module open_addressing_hash_table import oaht_pkg::*; #(
	parameter int TABLE_DEPTH = 16,
	parameter int KEY_WIDTH   = 32
) (
	input logic         clk,
	input logic         arst_n,
	oaht_req_if.sink    req,
	oaht_rsp_if.source  rsp,
	oaht_cfg_if.sink    cfg
);

	oaht_cmd_t cmd;
	oaht_sts_t sts;

	assign cfg.ready = 1'b1;

	oaht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	oaht_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_WIDTH   (KEY_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req.req_type),
		.req_key     (req.key),
		.cfg_we      (cfg.valid && cfg.ready),
		.cfg_addr    (cfg.addr),
		.cfg_data    (cfg.data),
		.status      (rsp.status),
		.slot_index  (rsp.slot_index),
		.probe_count (rsp.probe_count)
	);

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench of the open-addressing hash table, with its own table predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import oaht_pkg::*;

	typedef enum logic [1:0] {
		SLOT_EMPTY = 2'd0,
		SLOT_FULL  = 2'd1,
		SLOT_GONE  = 2'd2
	} slot_state_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  probes;
	} outcome_t;

	localparam int DEPTH = 16;
	localparam int PHASES = 11;
	localparam int PHASE_ITEMS = 90;

	class hash_scoreboard;
		logic [KEY_W-1:0] slot_keys [DEPTH];
		slot_state_t      slot_state [DEPTH];
		logic             probe_quad;
		logic [SZ_W-1:0]  size_reg;
		outcome_t         outcome_q [$];
		int               mismatches;

		function new();
			probe_quad = 1'b0;
			size_reg   = RESET_SIZE;
			mismatches = 0;
			wipe();
		endfunction

		function void wipe();
			for (int i = 0; i < DEPTH; i++) begin
				slot_keys[i]  = '0;
				slot_state[i] = SLOT_EMPTY;
			end
		endfunction

		function int unsigned span();
			if (size_reg < MIN_SIZE)
				return 32'(MIN_SIZE);
			if (size_reg > DEPTH)
				return DEPTH;
			return 32'(size_reg);
		endfunction

		function int unsigned probe_at(int unsigned home, int unsigned s, int unsigned n);
			int unsigned off;
			off = probe_quad ? s * s : s;
			return (home + off) % n;
		endfunction

		function void note_config(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
			if (addr == CFG_PROBE_MODE)
				probe_quad = data[0];
			else
				size_reg = data;
			wipe();
		endfunction

		function void note_request(logic [REQ_W-1:0] rt, logic [KEY_W-1:0] k);
			outcome_t    o;
			int unsigned n, home, idx, occ;
			bit          done;
			n    = span();
			home = k % n;
			o    = '{RES_OK, '0, '0};
			done = 1'b0;
			if (rt == REQ_CLEAR) begin
				wipe();
			end else if (rt == REQ_INSERT) begin
				occ = 0;
				for (int unsigned s = 0; s < n; s++) begin
					if (slot_state[s] == SLOT_FULL) begin
						if (!done && slot_keys[s] == k) begin
							o    = '{RES_DUP, '0, '0};
							done = 1'b1;
						end
						occ++;
					end
				end
				if (!done && occ >= n - 1) begin
					o    = '{RES_LOAD, '0, '0};
					done = 1'b1;
				end
				if (!done) begin
					o = '{RES_NO_SLOT, '0, n[CNT_W-1:0]};
					for (int unsigned s = 0; s < n; s++) begin
						idx = probe_at(home, s, n);
						if (!done && slot_state[idx] != SLOT_FULL) begin
							slot_keys[idx]  = k;
							slot_state[idx] = SLOT_FULL;
							o    = '{RES_OK, idx[SLOT_W-1:0], CNT_W'(s + 1)};
							done = 1'b1;
						end
					end
				end
			end else begin
				o = '{RES_NOT_FOUND, '0, n[CNT_W-1:0]};
				for (int unsigned s = 0; s < n; s++) begin
					idx = probe_at(home, s, n);
					if (!done) begin
						if (slot_state[idx] == SLOT_EMPTY) begin
							o    = '{RES_NOT_FOUND, '0, CNT_W'(s + 1)};
							done = 1'b1;
						end else if (slot_state[idx] == SLOT_FULL && slot_keys[idx] == k) begin
							if (rt == REQ_REMOVE)
								slot_state[idx] = SLOT_GONE;
							o    = '{RES_OK, idx[SLOT_W-1:0], CNT_W'(s + 1)};
							done = 1'b1;
						end
					end
				end
			end
			outcome_q.push_back(o);
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= 100)
				$display("tb: mismatch at %0t: %s", $time, what);
		endtask

		task check_response(logic [STAT_W-1:0] st, logic [SLOT_W-1:0] sl,
			logic [CNT_W-1:0] pc);
			outcome_t want;
			if (outcome_q.size() == 0) begin
				report($sformatf("unrequested word status=%0d slot=%0d probes=%0d", st, sl, pc));
				return;
			end
			want = outcome_q.pop_front();
			if (st !== want.status)
				report($sformatf("status %0d, predicted %0d", st, want.status));
			if (sl !== want.slot)
				report($sformatf("slot_index %0d, predicted %0d", sl, want.slot));
			if (pc !== want.probes)
				report($sformatf("probe_count %0d, predicted %0d", pc, want.probes));
		endtask
	endclass

	logic clk;
	logic arst_n;

	oaht_req_if req_ch ();
	oaht_rsp_if rsp_ch ();
	oaht_cfg_if cfg_ch ();

	open_addressing_hash_table uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	hash_scoreboard   table_check = new();
	logic [KEY_W-1:0] key_pool [$];

	int unsigned phase_mode [PHASES] = '{0, 1, 1, 0, 1, 0, 1, 0, 1, 0, 1};
	int unsigned phase_size [PHASES] = '{3, 3, 16, 16, 7, 2, 31, 0, 11, 17, 5};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("tb: FAIL");
		$finish;
	end

	task automatic send_req(input logic [REQ_W-1:0] rt, input logic [KEY_W-1:0] k);
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= rt;
		req_ch.key      <= k;
		do @(posedge clk); while (!req_ch.ready);
		table_check.note_request(rt, k);
	endtask

	task automatic send_cfg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= addr;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		table_check.note_config(addr, data);
	endtask

	task automatic drain(input int tail);
		while (table_check.pending() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key(input bit from_pool);
		int r;
		if (from_pool && key_pool.size() > 0)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		r = $urandom_range(0, 99);
		if (r < 15)
			return $urandom;
		return $urandom_range(0, 47);
	endfunction

	task automatic run_items(input int count);
		int               burst_left, r;
		logic [REQ_W-1:0] rt;
		logic [KEY_W-1:0] k;
		burst_left = $urandom_range(1, 40);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				rt = REQ_INSERT;
				k  = pick_key($urandom_range(0, 4) == 0);
				key_pool.push_back(k);
				if (key_pool.size() > 24)
					void'(key_pool.pop_front());
			end else if (r < 65) begin
				rt = REQ_SEARCH;
				k  = pick_key(1'($urandom_range(0, 1)));
			end else if (r < 97) begin
				rt = REQ_REMOVE;
				k  = pick_key(1'($urandom_range(0, 1)));
			end else begin
				rt = REQ_CLEAR;
				k  = $urandom;
			end
			send_req(rt, k);
			burst_left--;
			if (i == count - 1) begin
				req_ch.valid <= 1'b0;
			end else if (burst_left == 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 40);
			end
		end
	endtask

	initial begin
		int          seen, hold, stretch, style;
		bit          held;
		seen    = 0;
		hold    = 0;
		stretch = 0;
		style   = 0;
		held    = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				table_check.check_response(rsp_ch.status, rsp_ch.slot_index, rsp_ch.probe_count);
				seen++;
			end
			if (hold > 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else if (!held && seen == 300) begin
				held = 1'b1;
				hold = 400;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (stretch == 0) begin
					style   = $urandom_range(0, 2);
					stretch = $urandom_range(16, 96);
				end
				stretch--;
				case (style)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_SEARCH;
		req_ch.key      <= '0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.addr     <= CFG_PROBE_MODE;
		cfg_ch.data     <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// linear probing at reset size: collisions, tombstones, full path, refusals
		send_req(REQ_SEARCH, 32'd5);
		send_req(REQ_INSERT, 32'd0);
		send_req(REQ_INSERT, 32'd8);
		send_req(REQ_INSERT, 32'd16);
		send_req(REQ_INSERT, 32'hFFFF_FFFF);
		send_req(REQ_INSERT, 32'd8);
		send_req(REQ_SEARCH, 32'd16);
		send_req(REQ_REMOVE, 32'd8);
		send_req(REQ_SEARCH, 32'd16);
		send_req(REQ_SEARCH, 32'd24);
		send_req(REQ_INSERT, 32'd3);
		send_req(REQ_INSERT, 32'd4);
		send_req(REQ_INSERT, 32'd5);
		send_req(REQ_INSERT, 32'd6);
		send_req(REQ_SEARCH, 32'd24);
		send_req(REQ_REMOVE, 32'd9);
		send_req(REQ_INSERT, 32'd1);
		send_req(REQ_REMOVE, 32'd6);
		send_req(REQ_INSERT, 32'd14);
		send_req(REQ_SEARCH, 32'hFFFF_FFFF);
		send_req(REQ_CLEAR, 32'hA5A5_5A5A);
		send_req(REQ_SEARCH, 32'd0);
		req_ch.valid <= 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			drain(8);
			key_pool.delete();
			send_cfg(CFG_PROBE_MODE, {4'($urandom_range(0, 15)), phase_mode[p][0]});
			send_cfg(CFG_TABLE_SIZE, phase_size[p][CFG_DATA_W-1:0]);
			cfg_ch.valid <= 1'b0;
			run_items(PHASE_ITEMS);
		end

		drain(80);
		if (table_check.mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
